[rtl/page_table_map_and_walk_macros.svh]
// Assertion macros shared by the page table walker modules.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef PAGE_TABLE_MAP_AND_WALK_MACROS_SVH
`define PAGE_TABLE_MAP_AND_WALK_MACROS_SVH
`ifndef SYNTHESIS
`define PTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTW_ASSERT(label, prop, msg)
`define PTW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/ptw_pkg.sv]
package ptw_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned FRAME_W    = 40;
    localparam int unsigned IDX_W      = 9;
    localparam int unsigned VA_W       = 48;
    localparam int unsigned PA_W       = 52;
    localparam int unsigned FLAGS_W    = 6;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [0:0] CMD_MAP   = 1'b0;
    localparam logic [0:0] CMD_XLATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOTS   = 2'd2;

    typedef struct packed {
        logic [0:0]         command;
        logic [VA_W-1:0]    virtual_address;
        logic [PA_W-1:0]    physical_address;
        logic [FLAGS_W-1:0] entry_flags;
    } t_in_item;

    typedef struct packed {
        logic [PA_W-1:0]     page_address;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // Stored entry: only the bits an entry can ever hold.
    typedef struct packed {
        logic               nx;
        logic [FRAME_W-1:0] frame;
        logic [4:0]         flags;
    } t_pte;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_NOMAP,
        RES_NOSLOT,
        RES_PAGE
    } t_res;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ0,
        S_WALK,
        S_CHECK,
        S_CLEAR,
        S_LINK,
        S_LEAF,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_root;
        logic rd_next;
        logic clr_step;
        logic clr_root;
        logic link;
        logic leaf;
        logic res_load;
        t_res res_code;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       follows;
        logic       present;
        logic [1:0] lvl;
        logic       fits;
        logic       clr_last;
        logic       is_xlate;
    } t_dp_status;

    function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va, logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

    function automatic t_pte make_pte(logic [FRAME_W-1:0] frame, logic [FLAGS_W-1:0] flags);
        t_pte e;
        e.nx    = flags[5];
        e.frame = frame;
        e.flags = flags[4:0];
        return e;
    endfunction

endpackage

[rtl/ptw_dp.sv]
`include "page_table_map_and_walk_macros.svh"

module ptw_dp #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [ptw_pkg::FRAME_W-1:0]       i_cfg_data,
    input  ptw_pkg::t_in_item                 i_in_data,
    input  ptw_pkg::t_dp_cmd                  i_cmd,
    output ptw_pkg::t_dp_status               o_sts,
    output ptw_pkg::t_out_item                o_out_data
);

    localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int unsigned USED_W  = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned ADDR_W  = SLOT_W + ptw_pkg::IDX_W;
    localparam int unsigned DEPTH   = TABLE_SLOTS * 512;

    ptw_pkg::t_pte mem [DEPTH];

    logic [ptw_pkg::FRAME_W-1:0] r_base;
    ptw_pkg::t_in_item           r_item;
    logic [1:0]                  r_lvl;
    logic [SLOT_W-1:0]           r_slot;
    logic [USED_W-1:0]           r_used;
    logic [ptw_pkg::IDX_W-1:0]   r_clr_idx;
    ptw_pkg::t_pte               r_rdata;
    ptw_pkg::t_out_item          r_res;
    ptw_pkg::t_out_item          r_out;

    logic [ptw_pkg::FRAME_W-1:0] rel;
    logic                        follows;
    logic                        fits;
    logic [1:0]                  lvl_nxt;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    ptw_pkg::t_pte               wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [SLOT_W-1:0]           clr_slot;
    logic [ptw_pkg::IDX_W-1:0]   cur_idx;

    // A link is followed only into a slot that has been allocated.
    assign rel     = r_rdata.frame - r_base;
    assign follows = r_rdata.flags[0] && (rel < ptw_pkg::FRAME_W'(r_used));
    assign fits    = ((USED_W+1)'(r_used) + (USED_W+1)'(2'd3 - r_lvl))
                     <= (USED_W+1)'(TABLE_SLOTS);
    assign lvl_nxt = r_lvl + 2'd1;
    assign cur_idx = ptw_pkg::level_index(r_item.virtual_address, r_lvl);
    assign clr_slot = i_cmd.clr_root ? '0 : r_used[SLOT_W-1:0];

    always_comb begin
        wr_en   = i_cmd.clr_step || i_cmd.link || i_cmd.leaf;
        wr_addr = {r_slot, cur_idx};
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_addr = {clr_slot, r_clr_idx};
        end else if (i_cmd.link) begin
            wr_data = ptw_pkg::make_pte(r_base + ptw_pkg::FRAME_W'(r_used),
                                        r_item.entry_flags);
        end else if (i_cmd.leaf) begin
            wr_data = ptw_pkg::make_pte(r_item.physical_address[51:12],
                                        r_item.entry_flags);
        end
        rd_en   = i_cmd.rd_root || i_cmd.rd_next;
        if (i_cmd.rd_root) begin
            rd_addr = {{SLOT_W{1'b0}}, ptw_pkg::level_index(r_item.virtual_address, 2'd0)};
        end else begin
            rd_addr = {rel[SLOT_W-1:0],
                       ptw_pkg::level_index(r_item.virtual_address, lvl_nxt)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_used    <= USED_W'(1);
            r_clr_idx <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + ptw_pkg::IDX_W'(1);
            end
            if (i_cmd.link) begin
                r_used <= r_used + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
            r_lvl  <= 2'd0;
            r_slot <= '0;
        end else if (i_cmd.rd_next) begin
            r_lvl  <= lvl_nxt;
            r_slot <= rel[SLOT_W-1:0];
        end else if (i_cmd.link) begin
            r_lvl  <= lvl_nxt;
            r_slot <= r_used[SLOT_W-1:0];
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_code)
                ptw_pkg::RES_DONE: begin
                    r_res <= '{page_address: '0, status: ptw_pkg::ST_DONE};
                end
                ptw_pkg::RES_NOMAP: begin
                    r_res <= '{page_address: '0, status: ptw_pkg::ST_NOT_MAPPED};
                end
                ptw_pkg::RES_NOSLOT: begin
                    r_res <= '{page_address: '0, status: ptw_pkg::ST_NO_SLOTS};
                end
                default: begin
                    r_res <= '{page_address: {r_rdata.frame, 12'h000},
                               status: ptw_pkg::ST_DONE};
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts = '{follows:  follows,
                     present:  r_rdata.flags[0],
                     lvl:      r_lvl,
                     fits:     fits,
                     clr_last: (r_clr_idx == {ptw_pkg::IDX_W{1'b1}}),
                     is_xlate: (r_item.command == ptw_pkg::CMD_XLATE)};
    assign o_out_data = r_out;

    `PTW_ASSERT(a_used_range,
                (r_used >= USED_W'(1)) && (r_used <= USED_W'(TABLE_SLOTS)),
                "slot count out of range")
    `PTW_ASSERT(a_link_has_room,
                !i_cmd.link || (r_used < USED_W'(TABLE_SLOTS)),
                "allocation without a free slot")

endmodule

[rtl/ptw_ctrl.sv]
`include "page_table_map_and_walk_macros.svh"

module ptw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output ptw_pkg::t_dp_cmd    o_cmd,
    input  ptw_pkg::t_dp_status i_sts
);

    ptw_pkg::t_state r_state;
    ptw_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    ptw_pkg::t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptw_pkg::S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ptw_pkg::S_INIT: begin
                // The root table is swept to zero once after reset.
                cmd.clr_step = 1'b1;
                cmd.clr_root = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ptw_pkg::S_IDLE;
                end
            end
            ptw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ptw_pkg::S_READ0;
                end
            end
            ptw_pkg::S_READ0: begin
                cmd.rd_root = 1'b1;
                n_state     = ptw_pkg::S_WALK;
            end
            ptw_pkg::S_WALK: begin
                if (i_sts.lvl == 2'd3) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = i_sts.present ? ptw_pkg::RES_PAGE : ptw_pkg::RES_NOMAP;
                    n_state      = ptw_pkg::S_RESP;
                end else if (i_sts.follows) begin
                    cmd.rd_next = 1'b1;
                    if (!i_sts.is_xlate && i_sts.lvl == 2'd2) begin
                        n_state = ptw_pkg::S_LEAF;
                    end
                end else if (i_sts.is_xlate) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ptw_pkg::RES_NOMAP;
                    n_state      = ptw_pkg::S_RESP;
                end else begin
                    n_state = ptw_pkg::S_CHECK;
                end
            end
            ptw_pkg::S_CHECK: begin
                if (i_sts.fits) begin
                    n_state = ptw_pkg::S_CLEAR;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ptw_pkg::RES_NOSLOT;
                    n_state      = ptw_pkg::S_RESP;
                end
            end
            ptw_pkg::S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ptw_pkg::S_LINK;
                end
            end
            ptw_pkg::S_LINK: begin
                cmd.link = 1'b1;
                n_state  = (i_sts.lvl == 2'd2) ? ptw_pkg::S_LEAF : ptw_pkg::S_CLEAR;
            end
            ptw_pkg::S_LEAF: begin
                cmd.leaf     = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_code = ptw_pkg::RES_DONE;
                n_state      = ptw_pkg::S_RESP;
            end
            ptw_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ptw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptw_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ptw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    `PTW_ASSERT_NEXT(a_resp_delivers, (r_state == ptw_pkg::S_RESP) && (!r_out_valid || !i_out_stall), r_out_valid && (r_state == ptw_pkg::S_IDLE), "result not presented")
    `PTW_ASSERT(a_link_after_clear, (r_state != ptw_pkg::S_LINK) || ($past(r_state) == ptw_pkg::S_CLEAR), "link written before its table was cleared")
    `PTW_ASSERT(a_map_no_leaf_read, (r_state != ptw_pkg::S_WALK) || i_sts.is_xlate || (i_sts.lvl != 2'd3), "map walked into the leaf level")

endmodule

[rtl/page_table_map_and_walk.sv]
// Four-level page table keeper and walker.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one command:
// map a page or translate a virtual address. Output channel (o_out_valid /
// i_out_stall / o_out_data) returns one result per command: page address
// and status. The table base frame is written over a separate valid/ready
// port that is always ready; write it only while the block is idle.
// After reset the root table is swept to zero, one entry per cycle, and no
// command is accepted during the sweep. A translate, or a map that finds
// all three intermediate tables, runs through a load cycle, one dependent
// read per level of the table memory with registered read data, a result
// cycle and the output register load. The input stall drops in the cycle
// after that load, and the block takes no new command before then. A map
// adds, for its first fresh table, a slot check, a 512-entry clearing sweep
// and a link write, and for each further one a sweep and a link write. A
// map with too few free slots returns after its walk and slot check and
// changes nothing. Results sit in an output register: a stalled receiver
// holds the result steady, and the block takes the next command meanwhile
// but finishes it only once the output register is free.
module page_table_map_and_walk #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ptw_pkg::FRAME_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ptw_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ptw_pkg::t_out_item           o_out_data
);

    ptw_pkg::t_dp_cmd    cmd;
    ptw_pkg::t_dp_status sts;

    assign o_cfg_ready = 1'b1;

    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ptw_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
